FILE: rtl/core/vm_instruction_execute_unit_macros.svh
// Assertion macros for the execute unit's checker.
// Used by vmieu_checker.sv; each macro expects clk and rst in scope.
`ifndef VM_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define VM_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication.
`define VMIEU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VMIEU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/vmieu_pkg.sv
// Shared types and constants of the execute unit.
// No dependencies; used by the top level and its checker.
package vmieu_pkg;

  localparam int REG_COUNT_DEF = 32;
  localparam int MEM_BYTES_DEF = 65536;
  localparam int WORD_BYTES    = 8;

  localparam int IN_W  = 128;
  localparam int OUT_W = 136;

  typedef logic [4:0] op_t;
  localparam op_t OP_ADD   = 5'd0;
  localparam op_t OP_SUB   = 5'd1;
  localparam op_t OP_MUL   = 5'd2;
  localparam op_t OP_DIV   = 5'd3;
  localparam op_t OP_AND   = 5'd4;
  localparam op_t OP_OR    = 5'd5;
  localparam op_t OP_XOR   = 5'd6;
  localparam op_t OP_SLL   = 5'd7;
  localparam op_t OP_SRL   = 5'd8;
  localparam op_t OP_SRA   = 5'd9;
  localparam op_t OP_CMP   = 5'd10;
  localparam op_t OP_ADDI  = 5'd11;
  localparam op_t OP_SUBI  = 5'd12;
  localparam op_t OP_ANDI  = 5'd13;
  localparam op_t OP_ORI   = 5'd14;
  localparam op_t OP_XORI  = 5'd15;
  localparam op_t OP_LI    = 5'd16;
  localparam op_t OP_LOAD  = 5'd17;
  localparam op_t OP_STORE = 5'd18;
  localparam op_t OP_JMP   = 5'd19;
  localparam op_t OP_JR    = 5'd20;
  localparam op_t OP_BEQ   = 5'd21;
  localparam op_t OP_BNE   = 5'd22;
  localparam op_t OP_HALT  = 5'd23;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_BADREG  = 3'd1;
  localparam status_t ST_BADADDR = 3'd2;
  localparam status_t ST_DIVZERO = 3'd3;
  localparam status_t ST_HALTED  = 3'd4;
  localparam status_t ST_IGNORED = 3'd5;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] mem_address;
    logic [63:0] imm_value;
    logic [7:0]  src2_index;
    logic [7:0]  src1_index;
    logic [7:0]  dest_index;
    op_t         req_type;
  } in_item_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]  pad;
    logic        neg_bit;
    logic        zero_bit;
    logic [63:0] result_value;
    logic [63:0] pc_value;
    status_t     status_code;
    logic        run_flag;
  } out_item_t;

endpackage

FILE: rtl/core/vmieu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vmieu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/vm_instruction_execute_unit.sv
// Execute unit of a small 64-bit machine: register file, byte data memory, pc and flags.
// Depends on vmieu_pkg and vmieu_ram.
//
//   channel   | dir | handshake                   | payload
//   ----------+-----+-----------------------------+--------------------------------
//   s_axis    | in  | s_axis_tvalid/s_axis_tready | one decoded instruction
//   m_axis    | out | m_axis_tvalid/m_axis_tready | status, pc, result and flags
//
// Steps: most instructions read registers and memory, then execute and write back. A
// multiply builds the low 64 bits of its 64 by 64 product from three registered 32 by
// 32 partial products. A divide runs the restoring divider, one quotient bit per cycle.
// Reset clears pc, flags and the register file's valid bits (an entry never written
// reads as zero) and sets the machine running. The data memory is not cleared.
// A new item is taken while the previous result still waits at the output register;
// the finishing cycle of an item waits until that register is free.
module vm_instruction_execute_unit #(
  parameter int REG_COUNT = vmieu_pkg::REG_COUNT_DEF,
  parameter int MEM_BYTES = vmieu_pkg::MEM_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // req_type[4:0], dest_index[12:5], src1_index[20:13], src2_index[28:21],
  // imm_value[92:29], mem_address[124:93], zero fill above
  input  logic [vmieu_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // run_flag[0], status_code[3:1], pc_value[67:4], result_value[131:68],
  // zero_bit[132], neg_bit[133], zero fill above
  output logic [vmieu_pkg::OUT_W-1:0] m_axis_tdata
);
  import vmieu_pkg::*;

  localparam int RA_W   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int ROWS   = (MEM_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W = $clog2(WORD_BYTES);
  localparam logic [32:0] ADDR_MAX = 33'(MEM_BYTES - WORD_BYTES);
  localparam logic [8:0]  REG_LIM  = 9'(REG_COUNT);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_DONE} state_t;

  state_t          state;
  in_item_t        ins;
  logic [63:0]     pc;
  logic            zf;
  logic            nf;
  logic            running;
  logic [REG_COUNT-1:0] rf_valid;
  logic            out_valid;
  out_item_t       out_data;
  logic [63:0]     pp0;
  logic [31:0]     pp1;
  logic [31:0]     pp2;
  logic [63:0]     done_res;
  logic [63:0]     dq;
  logic [63:0]     dr;
  logic [63:0]     dd;
  logic [5:0]      dcnt;

  in_item_t in_word;
  in_item_t cur;
  assign in_word = s_axis_tdata;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Read addresses follow the incoming item while idle, then stay on the held item so
  // that read data stays valid through an output stall.
  assign cur = (state == S_IDLE) ? in_word : ins;

  // Register file: two copies written alike, one per read port.
  logic [RA_W-1:0] ra_addr;
  logic [RA_W-1:0] rb_addr;
  logic [63:0]     ra_q;
  logic [63:0]     rb_q;
  logic            rf_we;
  logic [63:0]     c_res;

  assign ra_addr = (cur.req_type == OP_STORE) ? cur.dest_index[RA_W-1:0]
                                              : cur.src1_index[RA_W-1:0];
  assign rb_addr = cur.src2_index[RA_W-1:0];

  vmieu_ram #(.WIDTH(64), .DEPTH(REG_COUNT)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(ins.dest_index[RA_W-1:0]), .wdata(c_res),
    .raddr(ra_addr), .rdata(ra_q)
  );
  vmieu_ram #(.WIDTH(64), .DEPTH(REG_COUNT)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(ins.dest_index[RA_W-1:0]), .wdata(c_res),
    .raddr(rb_addr), .rdata(rb_q)
  );

  // Operand qualification on the held item.
  logic        rd_ok, r1_ok, r2_ok;
  logic [63:0] a, b, st_word;
  assign rd_ok = {1'b0, ins.dest_index} < REG_LIM;
  assign r1_ok = {1'b0, ins.src1_index} < REG_LIM;
  assign r2_ok = {1'b0, ins.src2_index} < REG_LIM;
  assign a = (r1_ok && rf_valid[ins.src1_index[RA_W-1:0]]) ? ra_q : '0;
  assign b = (r2_ok && rf_valid[ins.src2_index[RA_W-1:0]]) ? rb_q : '0;
  assign st_word = (rd_ok && rf_valid[ins.dest_index[RA_W-1:0]]) ? ra_q : '0;

  // Data memory: eight byte lanes, so that an unaligned word touches each lane once.
  logic [LANE_W-1:0] cur_off;
  logic [RW-1:0]     cur_row;
  logic [LANE_W-1:0] ins_off;
  logic              mem_we;
  logic [7:0]        lane_q [WORD_BYTES];
  logic [63:0]       ld_word;

  assign cur_off = cur.mem_address[LANE_W-1:0];
  assign cur_row = cur.mem_address[RW+LANE_W-1:LANE_W];
  assign ins_off = ins.mem_address[LANE_W-1:0];

  for (genvar l = 0; l < WORD_BYTES; l++) begin : g_lane
    logic [RW-1:0]     row;
    logic [LANE_W-1:0] byte_sel;
    logic [63:0]       shifted;
    assign row      = cur_row + RW'(LANE_W'(l) < cur_off);
    assign byte_sel = LANE_W'(l) - ins_off;
    assign shifted  = st_word >> {byte_sel, 3'b000};
    vmieu_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
      .clk(clk), .we(mem_we), .waddr(row), .wdata(shifted[7:0]),
      .raddr(row), .rdata(lane_q[l])
    );
  end

  always_comb begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      ld_word[8*i +: 8] = lane_q[LANE_W'(ins_off + LANE_W'(i))];
    end
  end

  // Execute stage of the held item.
  status_t     ex_status;
  logic [63:0] ex_res;
  logic        ex_rf_we, ex_mem_we, ex_pc_we, ex_flag_we, ex_zero, ex_neg;
  logic        ex_mul, ex_div;
  logic [63:0] ex_pc;
  logic        three_ok, two_ok, addr_ok;

  assign three_ok = rd_ok && r1_ok && r2_ok;
  assign two_ok   = rd_ok && r1_ok;
  assign addr_ok  = {1'b0, ins.mem_address} <= ADDR_MAX;

  always_comb begin
    ex_status  = ST_OK;
    ex_res     = '0;
    ex_rf_we   = 1'b0;
    ex_mem_we  = 1'b0;
    ex_pc_we   = 1'b0;
    ex_pc      = pc;
    ex_flag_we = 1'b0;
    ex_zero    = (a == b);
    ex_neg     = $signed(a) < $signed(b);
    ex_mul     = 1'b0;
    ex_div     = 1'b0;
    if (!running) begin
      ex_status = ST_IGNORED;
    end else begin
      case (ins.req_type) inside
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR, OP_SLL, OP_SRL,
        OP_SRA: begin
          if (!three_ok) begin
            ex_status = ST_BADREG;
          end else begin
            ex_rf_we = 1'b1;
            case (ins.req_type)
              OP_ADD:  ex_res = a + b;
              OP_SUB:  ex_res = a - b;
              OP_AND:  ex_res = a & b;
              OP_OR:   ex_res = a | b;
              OP_XOR:  ex_res = a ^ b;
              OP_SLL:  ex_res = a << b[5:0];
              OP_SRL:  ex_res = a >> b[5:0];
              OP_SRA:  ex_res = $unsigned($signed(a) >>> b[5:0]);
              OP_MUL:  ex_mul = 1'b1;
              default: begin
                if (b == '0) begin
                  ex_status = ST_DIVZERO;
                  ex_rf_we  = 1'b0;
                end else begin
                  ex_div = 1'b1;
                end
              end
            endcase
          end
        end
        OP_CMP: begin
          if (!(r1_ok && r2_ok)) ex_status = ST_BADREG;
          else ex_flag_we = 1'b1;
        end
        OP_ADDI, OP_SUBI, OP_ANDI, OP_ORI, OP_XORI: begin
          if (!two_ok) begin
            ex_status = ST_BADREG;
          end else begin
            ex_rf_we = 1'b1;
            case (ins.req_type)
              OP_ADDI: ex_res = a + ins.imm_value;
              OP_SUBI: ex_res = a - ins.imm_value;
              OP_ANDI: ex_res = a & ins.imm_value;
              OP_ORI:  ex_res = a | ins.imm_value;
              default: ex_res = a ^ ins.imm_value;
            endcase
          end
        end
        OP_LI: begin
          if (!rd_ok) begin
            ex_status = ST_BADREG;
          end else begin
            ex_rf_we = 1'b1;
            ex_res   = ins.imm_value;
          end
        end
        OP_LOAD, OP_STORE: begin
          if (!rd_ok) begin
            ex_status = ST_BADREG;
          end else if (!addr_ok) begin
            ex_status = ST_BADADDR;
          end else if (ins.req_type == OP_LOAD) begin
            ex_rf_we = 1'b1;
            ex_res   = ld_word;
          end else begin
            ex_mem_we = 1'b1;
            ex_res    = st_word;
          end
        end
        OP_JMP: begin
          ex_pc_we = 1'b1;
          ex_pc    = {32'b0, ins.mem_address};
        end
        OP_JR: begin
          if (!r1_ok) begin
            ex_status = ST_BADREG;
          end else begin
            ex_pc_we = 1'b1;
            ex_pc    = a;
          end
        end
        OP_BEQ, OP_BNE: begin
          if (!(r1_ok && r2_ok)) begin
            ex_status = ST_BADREG;
          end else if ((ins.req_type == OP_BEQ) == (a == b)) begin
            ex_pc_we = 1'b1;
            ex_pc    = pc + ins.imm_value;
          end
        end
        OP_HALT: ex_status = ST_HALTED;
        default: ex_status = ST_OK;
      endcase
    end
  end

  // Commit: the execute stage finishes simple items, the done stage multiply and divide.
  logic    fin, out_free, commit, c_rf_we, c_run;
  status_t c_status;

  assign fin      = ((state == S_EXEC) && !ex_mul && !ex_div) || (state == S_DONE);
  assign out_free = !out_valid || m_axis_tready;
  assign commit   = fin && out_free;
  assign c_status = (state == S_DONE) ? ST_OK : ex_status;
  assign c_rf_we  = (state == S_DONE) || ex_rf_we;
  assign c_res    = (state == S_DONE) ? done_res
                  : ((ex_status == ST_OK) ? ex_res : '0);
  assign c_run    = running && (c_status == ST_OK);
  assign rf_we    = commit && c_rf_we && (c_status == ST_OK);
  assign mem_we   = commit && (state == S_EXEC) && ex_mem_we;

  // Partial products of the low 64 bits of a 64 by 64 product.
  logic [63:0] m0, m1, m2;
  assign m0 = a[31:0] * b[31:0];
  assign m1 = a[31:0] * b[63:32];
  assign m2 = a[63:32] * b[31:0];

  // One restoring divide step per cycle.
  logic [64:0] rsh;
  logic [65:0] dif;
  logic        ge;
  assign rsh = {dr, dq[63]};
  assign dif = {1'b0, rsh} - {2'b00, dd};
  assign ge  = !dif[65];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      zf        <= 1'b0;
      nf        <= 1'b0;
      running   <= 1'b1;
      rf_valid  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && !commit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            ins   <= in_word;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ex_mul) begin
            pp0   <= m0;
            pp1   <= m1[31:0];
            pp2   <= m2[31:0];
            state <= S_MUL;
          end else if (ex_div) begin
            dq    <= a;
            dr    <= '0;
            dd    <= b;
            dcnt  <= 6'd63;
            state <= S_DIV;
          end
        end
        S_MUL: begin
          done_res <= pp0 + {pp1 + pp2, 32'b0};
          state    <= S_DONE;
        end
        S_DIV: begin
          dr   <= ge ? dif[63:0] : rsh[63:0];
          dq   <= {dq[62:0], ge};
          dcnt <= dcnt - 6'd1;
          if (dcnt == '0) begin
            done_res <= {dq[62:0], ge};
            state    <= S_DONE;
          end
        end
        S_DONE: begin
        end
        default: state <= S_IDLE;
      endcase
      if (commit) begin
        state     <= S_IDLE;
        running   <= c_run;
        out_valid <= 1'b1;
        if (c_status == ST_OK && ex_pc_we && state == S_EXEC) pc <= ex_pc;
        if (c_status == ST_OK && ex_flag_we && state == S_EXEC) begin
          zf <= ex_zero;
          nf <= ex_neg;
        end
        if (rf_we) rf_valid[ins.dest_index[RA_W-1:0]] <= 1'b1;
        out_data.pad          <= '0;
        out_data.run_flag     <= c_run;
        out_data.status_code  <= c_status;
        out_data.pc_value     <= (c_status == ST_OK && ex_pc_we && state == S_EXEC)
                                 ? ex_pc : pc;
        out_data.result_value <= c_res;
        out_data.zero_bit     <= (c_status == ST_OK && ex_flag_we && state == S_EXEC)
                                 ? ex_zero : zf;
        out_data.neg_bit      <= (c_status == ST_OK && ex_flag_we && state == S_EXEC)
                                 ? ex_neg : nf;
      end
    end
  end

endmodule

FILE: rtl/core/vmieu_checker.sv
// Port-level checker of the execute unit, bound to the top level.
// Depends on vmieu_pkg and vm_instruction_execute_unit_macros.svh.
`include "vm_instruction_execute_unit_macros.svh"

module vmieu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [vmieu_pkg::OUT_W-1:0] m_axis_tdata
);
  import vmieu_pkg::*;

  out_item_t o;
  logic      seen_stop;
  assign o = m_axis_tdata;

  // Set once a delivered item reports a stopped machine.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_stop <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && !o.run_flag) begin
      seen_stop <= 1'b1;
    end
  end

  `VMIEU_ASSERT_IMP(a_err_stops, m_axis_tvalid && o.status_code != ST_OK, !o.run_flag, "error or halt left the machine running")
  `VMIEU_ASSERT_IMP(a_stays_stopped, m_axis_tvalid && seen_stop, !o.run_flag && o.status_code == ST_IGNORED, "item executed after the machine stopped")
  `VMIEU_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `VMIEU_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item was in flight")

endmodule

bind vm_instruction_execute_unit vmieu_checker u_vmieu_checker (.*);
